// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// clocked checks that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check under reset: disabled while the reset is active
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/ufst_pkg.sv -----
// ----------------------------------------------------------------------------
// ufst_pkg: shared types and constants
// item, result and status types of the udp flow statistics table
// ----------------------------------------------------------------------------
package ufst_pkg;

    localparam logic [2:0] KIND_HIT   = 3'd0;
    localparam logic [2:0] KIND_NEW   = 3'd1;
    localparam logic [2:0] KIND_FULL  = 3'd2;
    localparam logic [2:0] KIND_DUMP  = 3'd3;
    localparam logic [2:0] KIND_EMPTY = 3'd4;

    localparam logic [31:0] PTP_MCAST_ADDR = 32'hE000_0181;
    localparam logic [31:0] BCAST_ADDR     = 32'hFFFF_FFFF;
    localparam logic [31:0] PKT_MAX        = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_MAX       = 48'hFFFF_FFFF_FFFF;

    localparam int USED_W = 7;

    typedef struct packed {
        logic        cmd;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] pkt_length;
        logic        sys;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] pkt_total;
        logic [47:0] byte_total;
        logic        sys;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] level;
        logic       push;
        logic       pop;
    } t_fifo_stat;

    typedef struct packed {
        logic [USED_W-1:0] used;
    } t_back_stat;

    function automatic logic is_system_dst(input logic [31:0] dst);
        return (dst == PTP_MCAST_ADDR) || (dst == BCAST_ADDR);
    endfunction

endpackage

// ----- sv/ufst_front.sv -----
// ----------------------------------------------------------------------------
// ufst_front: input side
// accepts items, classifies the destination and queues them two deep
// ----------------------------------------------------------------------------
module ufst_front import ufst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_item      i_item,
    output logic       o_ready,
    output logic       o_head_valid,
    output t_item      o_head,
    input  logic       i_pop,
    output t_fifo_stat o_stat
);

    t_item      r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_level;
    logic       push;
    t_item      cls;

    always_comb begin
        cls     = i_item;
        cls.sys = is_system_dst(i_item.dst_addr);
    end

    assign o_ready      = (r_level != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_head_valid = (r_level != 2'd0);
    assign o_head       = r_q[r_rptr];
    assign o_stat       = '{level: r_level, push: push, pop: i_pop && o_head_valid};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop && o_head_valid) begin
                r_rptr <= ~r_rptr;
            end
            r_level <= r_level + 2'(push) - 2'(i_pop && o_head_valid);
        end
    end

endmodule

// ----- sv/ufst_back.sv -----
// ----------------------------------------------------------------------------
// ufst_back: flow table engine
// key match, counter update, append and dump sequencing with output register
// ----------------------------------------------------------------------------
module ufst_back import ufst_pkg::*; #(
    parameter int FLOW_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_skip,
    input  logic       i_head_valid,
    input  t_item      i_head,
    output logic       o_pop,
    output logic       o_res_valid,
    output t_result    o_res,
    input  logic       i_res_ready,
    output t_back_stat o_stat
);

    localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(FLOW_ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MATCH = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_DREAD = 3'd3;
    localparam logic [2:0] S_DCHK  = 3'd4;
    localparam logic [2:0] S_DEND  = 3'd5;

    // key lanes
    logic [31:0] r_ksa  [FLOW_ENTRIES];
    logic [31:0] r_kda  [FLOW_ENTRIES];
    logic [15:0] r_ksp  [FLOW_ENTRIES];
    logic [15:0] r_kdp  [FLOW_ENTRIES];
    logic        r_ksys [FLOW_ENTRIES];
    // counter memory: packets in the top 32 bits, bytes below
    logic [79:0] r_cnt  [FLOW_ENTRIES];
    logic [79:0] r_rd;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_ptr, n_ptr;
    t_item         r_item, n_item;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_pend_v, n_pend_v;
    logic [IW-1:0] r_pend_idx, n_pend_idx;
    logic [31:0]   r_pend_pk, n_pend_pk;
    logic [47:0]   r_pend_by, n_pend_by;
    logic          r_pend_sys, n_pend_sys;
    logic          r_out_v, n_out_v;
    t_result       r_out, n_out;

    logic          rd_en, wr_en, key_we;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [79:0]   wr_data;
    logic          any_hit;
    logic [IW-1:0] hit_idx;
    logic          out_free;
    logic [31:0]   cur_pk, upd_pk;
    logic [47:0]   cur_by, upd_by;
    logic [48:0]   by_sum;
    logic          listed;

    // parallel compare, first match wins
    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int j = FLOW_ENTRIES - 1; j >= 0; j--) begin
            if ((CW'(j) < r_used) && r_ksa[j] == r_item.src_addr &&
                r_kda[j] == r_item.dst_addr && r_ksp[j] == r_item.sport &&
                r_kdp[j] == r_item.dport) begin
                any_hit = 1'b1;
                hit_idx = IW'(j);
            end
        end
    end

    assign out_free = !r_out_v || i_res_ready;
    assign cur_pk   = r_rd[79:48];
    assign cur_by   = r_rd[47:0];
    assign upd_pk   = (cur_pk == PKT_MAX) ? cur_pk : cur_pk + 32'd1;
    assign by_sum   = {1'b0, cur_by} + {33'd0, r_item.pkt_length};
    assign upd_by   = by_sum[48] ? BYTE_MAX : by_sum[47:0];
    assign listed   = (cur_pk != '0) && !(i_skip && r_ksys[r_ptr[IW-1:0]]);

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_ptr      = r_ptr;
        n_item     = r_item;
        n_hit      = r_hit;
        n_idx      = r_idx;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_pend_pk  = r_pend_pk;
        n_pend_by  = r_pend_by;
        n_pend_sys = r_pend_sys;
        n_out_v    = r_out_v && !i_res_ready;
        n_out      = r_out;
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        key_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop    = 1'b1;
                    n_item   = i_head;
                    n_ptr    = '0;
                    n_pend_v = 1'b0;
                    n_state  = i_head.cmd ? S_DREAD : S_MATCH;
                end
            end
            S_MATCH: begin
                n_hit   = any_hit;
                n_idx   = hit_idx;
                rd_en   = 1'b1;
                rd_addr = hit_idx;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_out_v  = 1'b1;
                    n_out    = '{kind: KIND_FULL, src_addr: r_item.src_addr,
                                 dst_addr: r_item.dst_addr, sport: r_item.sport,
                                 dport: r_item.dport, pkt_total: '0,
                                 byte_total: '0, sys: r_item.sys, last: 1'b1};
                    if (r_hit) begin
                        wr_en            = 1'b1;
                        wr_addr          = r_idx;
                        wr_data          = {upd_pk, upd_by};
                        n_out.kind       = KIND_HIT;
                        n_out.pkt_total  = upd_pk;
                        n_out.byte_total = upd_by;
                    end else if (r_used < CW'(FLOW_ENTRIES)) begin
                        wr_en            = 1'b1;
                        key_we           = 1'b1;
                        wr_addr          = r_used[IW-1:0];
                        wr_data          = {32'd1, 32'd0, r_item.pkt_length};
                        n_used           = r_used + CW'(1);
                        n_out.kind       = KIND_NEW;
                        n_out.pkt_total  = 32'd1;
                        n_out.byte_total = {32'd0, r_item.pkt_length};
                    end
                    n_state = S_IDLE;
                end
            end
            S_DREAD: begin
                if (r_ptr == r_used) begin
                    n_state = S_DEND;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr[IW-1:0];
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (!listed) begin
                    n_ptr   = r_ptr + CW'(1);
                    n_state = S_DREAD;
                end else if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = '{kind: KIND_DUMP, src_addr: r_ksa[r_pend_idx],
                                    dst_addr: r_kda[r_pend_idx],
                                    sport: r_ksp[r_pend_idx],
                                    dport: r_kdp[r_pend_idx], pkt_total: r_pend_pk,
                                    byte_total: r_pend_by, sys: r_pend_sys, last: 1'b0};
                    end
                    n_pend_v   = 1'b1;
                    n_pend_idx = r_ptr[IW-1:0];
                    n_pend_pk  = cur_pk;
                    n_pend_by  = cur_by;
                    n_pend_sys = r_ksys[r_ptr[IW-1:0]];
                    wr_en      = 1'b1;
                    wr_addr    = r_ptr[IW-1:0];
                    wr_data    = '0;
                    n_ptr      = r_ptr + CW'(1);
                    n_state    = S_DREAD;
                end
            end
            S_DEND: begin
                if (out_free) begin
                    n_out_v = 1'b1;
                    if (r_pend_v) begin
                        n_out = '{kind: KIND_DUMP, src_addr: r_ksa[r_pend_idx],
                                  dst_addr: r_kda[r_pend_idx], sport: r_ksp[r_pend_idx],
                                  dport: r_kdp[r_pend_idx], pkt_total: r_pend_pk,
                                  byte_total: r_pend_by, sys: r_pend_sys, last: 1'b1};
                    end else begin
                        n_out      = '0;
                        n_out.kind = KIND_EMPTY;
                        n_out.last = 1'b1;
                    end
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // counter memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cnt[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_cnt[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_ksa[wr_addr]  <= r_item.src_addr;
            r_kda[wr_addr]  <= r_item.dst_addr;
            r_ksp[wr_addr]  <= r_item.sport;
            r_kdp[wr_addr]  <= r_item.dport;
            r_ksys[wr_addr] <= r_item.sys;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_hit      <= n_hit;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_pend_pk  <= n_pend_pk;
        r_pend_by  <= n_pend_by;
        r_pend_sys <= n_pend_sys;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ptr    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_ptr    <= n_ptr;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;
    assign o_stat      = '{used: USED_W'(r_used)};

endmodule

// ----- sv/udp_flow_stats_table.sv -----
// ----------------------------------------------------------------------------
// udp_flow_stats_table: per-flow packet and byte counters
// counts udp packets per 4-tuple, appends new flows and dumps the table
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s (item)  in   i_s_tvalid/o_s_tready   tdata keys+length, tuser cmd
//  m (res)   out  o_m_tvalid/i_m_tready   tdata flow+totals, tuser kind+sys, tlast
//  apb cfg   in   psel/penable/pready     register skip_system at byte address 0
//
//  a packet moves through the engine in order: queue pop, parallel key match
//  with counter read, then counter update or append with the result load
//  a dump pops, reads and checks each table entry in turn through the single
//  read port of the counter memory, then runs the end check and final load;
//  each listed entry is held one step so that the final one can carry tlast
//  reset is synchronous, active low; the table is empty after it
//  a two deep queue in front keeps taking items, until it is full, while the
//  engine or the output register is stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udp_flow_stats_table import ufst_pkg::*; #(
    parameter int FLOW_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // item channel
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,  // src addr, dst addr, src port, dst port, length
    input  logic         i_s_tuser,  // cmd
    // result channel
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [175:0] o_m_tdata,  // flow src addr, flow dst addr, flow src port,
                                     // flow dst port, packet_total, byte_total
    output logic [3:0]   o_m_tuser,  // kind, system_flow
    output logic         o_m_tlast,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [2:0] ADDR_SKIP_SYSTEM = 3'd0;
    localparam logic [USED_W-1:0] USED_MAX = USED_W'(FLOW_ENTRIES);

    logic              r_skip;
    t_item             in_item;
    t_item             head;
    logic              head_valid, pop;
    t_result           res;
    t_fifo_stat        fstat;
    t_back_stat        bstat;
    logic [1:0]        lvl;
    logic              up_only;
    logic [USED_W-1:0] used_cnt;

    // apb register, writes land on the access cycle
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SKIP_SYSTEM) ? {31'd0, r_skip} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_SKIP_SYSTEM) begin
            r_skip <= pwdata[0];
        end
    end

    // unpack the item transfer
    always_comb begin
        in_item            = '0;
        in_item.cmd        = i_s_tuser;
        in_item.src_addr   = i_s_tdata[31:0];
        in_item.dst_addr   = i_s_tdata[63:32];
        in_item.sport      = i_s_tdata[79:64];
        in_item.dport      = i_s_tdata[95:80];
        in_item.pkt_length = i_s_tdata[111:96];
    end

    ufst_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .i_item       (in_item),
        .o_ready      (o_s_tready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop),
        .o_stat       (fstat)
    );

    ufst_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_skip       (r_skip),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_res_valid  (o_m_tvalid),
        .o_res        (res),
        .i_res_ready  (i_m_tready),
        .o_stat       (bstat)
    );

    // pack the result transfer
    assign o_m_tdata = {res.byte_total, res.pkt_total, res.dport, res.sport,
                        res.dst_addr, res.src_addr};
    assign o_m_tuser = {res.sys, res.kind};
    assign o_m_tlast = res.last;

    assign lvl      = fstat.level;
    assign up_only  = fstat.push && !fstat.pop;
    assign used_cnt = bstat.used;

    // queue never overfills and tracks push without pop
    `ASSERT_RST(a_fifo_level, i_clk, i_rst_n, lvl != 2'd3, "queue level out of range")
    `ASSERT_RST(a_fifo_push, i_clk, i_rst_n, up_only |=> lvl == $past(lvl) + 2'd1, "push lost")
    // the table only grows and never past its size
    `ASSERT_RST(a_used_grow, i_clk, i_rst_n, used_cnt >= $past(used_cnt), "flow count shrank")
    `ASSERT_RST(a_used_max, i_clk, i_rst_n, used_cnt <= USED_MAX, "flow count overran")

endmodule
